[design/tlat_pkg.sv]
package tlat_pkg;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_OWN   = 6'b001000,
    S_EVICT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // control from the sequencer to the tlb
  typedef struct packed {
    logic fill_en;
    logic inv_en;
  } tlb_ctl_t;

  // result beat layout
  localparam int unsigned OUT_BITS = 40;
  localparam int unsigned PHYS_W   = 15;
  localparam int unsigned FNUM_W   = 7;
  localparam int unsigned EPAGE_W  = 8;
  localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

endpackage

[design/tlat_tlb.sv]
module tlat_tlb
  import tlat_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int PAGE_W  = 8,
  parameter int FRAME_W = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [PAGE_W-1:0]  look_page,
  output logic               look_hit,
  output logic [FRAME_W-1:0] look_frame,
  input  tlb_ctl_t           ctl,
  input  logic [PAGE_W-1:0]  fill_page,
  input  logic [FRAME_W-1:0] fill_frame,
  input  logic [PAGE_W-1:0]  inv_page
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0] valid_r;
  logic [PAGE_W-1:0]  tag_r  [ENTRIES];
  logic [FRAME_W-1:0] data_r [ENTRIES];
  logic [IDX_W-1:0]   fill_ptr_r;
  logic [IDX_W-1:0]   fill_ptr_nxt;
  logic [ENTRIES-1:0] inv_sel;

  // lookup, lowest matching entry wins
  always_comb begin
    look_hit   = 1'b0;
    look_frame = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == look_page) begin
        look_hit   = 1'b1;
        look_frame = data_r[i];
      end
    end
  end

  // first entry holding the evicted page
  always_comb begin
    inv_sel = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == inv_page) begin
        inv_sel    = '0;
        inv_sel[i] = 1'b1;
      end
    end
  end

  // fifo refill pointer
  always_comb begin
    if (fill_ptr_r == IDX_W'(ENTRIES - 1)) begin
      fill_ptr_nxt = '0;
    end else begin
      fill_ptr_nxt = fill_ptr_r + 1'b1;
    end
  end

  // valid bits and pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_ptr_r <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (ctl.inv_en && inv_sel[i]) begin
          valid_r[i] <= 1'b0;
        end
      end
      if (ctl.fill_en) begin
        valid_r[fill_ptr_r] <= 1'b1;
        fill_ptr_r          <= fill_ptr_nxt;
      end
    end
  end

  // tags and frames, fill overrides invalidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        data_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (ctl.inv_en && inv_sel[i]) begin
          data_r[i] <= '0;
        end
      end
      if (ctl.fill_en) begin
        tag_r[fill_ptr_r]  <= fill_page;
        data_r[fill_ptr_r] <= fill_frame;
      end
    end
  end

endmodule

[design/tlat_frames.sv]
module tlat_frames
  import tlat_pkg::*;
#(
  parameter int FRAMES  = 128,
  parameter int PAGE_W  = 8,
  parameter int FRAME_W = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               scan_start,
  output logic               scan_done,
  output logic [FRAME_W-1:0] best_idx,
  input  logic               stamp_we,
  input  logic [FRAME_W-1:0] stamp_waddr,
  input  logic [31:0]        stamp_wdata,
  input  logic               owner_we,
  input  logic [FRAME_W-1:0] owner_waddr,
  input  logic [PAGE_W-1:0]  owner_wdata,
  input  logic               owner_re,
  input  logic [FRAME_W-1:0] owner_raddr,
  output logic [PAGE_W-1:0]  owner_rdata
);

  localparam int CNT_W = $clog2(FRAMES + 1);

  logic [31:0]        stamp_mem [FRAMES];
  logic [PAGE_W-1:0]  owner_mem [FRAMES];
  logic [31:0]        stamp_q_r;
  logic [PAGE_W-1:0]  owner_q_r;
  logic [CNT_W-1:0]   iss_r;
  logic               busy_r;
  logic               cmp_v_r;
  logic [FRAME_W-1:0] cmp_idx_r;
  logic [31:0]        best_stamp_r;
  logic [FRAME_W-1:0] best_idx_r;
  logic               done_r;
  logic               iss_go;

  assign iss_go      = busy_r && (iss_r < CNT_W'(FRAMES));
  assign scan_done   = done_r;
  assign best_idx    = best_idx_r;
  assign owner_rdata = owner_q_r;

  // stamp memory, one read port for the scan
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    stamp_q_r <= stamp_mem[iss_r[FRAME_W-1:0]];
  end

  // owner memory
  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[owner_waddr] <= owner_wdata;
    end
    if (owner_re) begin
      owner_q_r <= owner_mem[owner_raddr];
    end
  end

  // scan control: issue one read per cycle, compare in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      iss_r   <= '0;
      cmp_v_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r  <= cmp_v_r && (cmp_idx_r == FRAME_W'(FRAMES - 1));
      cmp_v_r <= iss_go;
      if (scan_start) begin
        busy_r <= 1'b1;
        iss_r  <= '0;
      end else if (iss_go) begin
        iss_r <= iss_r + 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  // running minimum, strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (iss_go) begin
      cmp_idx_r <= iss_r[FRAME_W-1:0];
    end
    if (cmp_v_r) begin
      if (cmp_idx_r == '0 || stamp_q_r < best_stamp_r) begin
        best_stamp_r <= stamp_q_r;
        best_idx_r   <= cmp_idx_r;
      end
    end
  end

endmodule

[design/tlb_lru_address_translator.sv]
// Address translator with a tlb, a page table and lru frame replacement.
// in channel: one beat per 16-bit logical address (page in bits 15..8,
// offset in bits 7..0). out channel: one beat per input beat carrying the
// physical address, frame, tlb hit, page fault and eviction fields.
// A tlb hit or page table hit goes from the input beat through S_LOOK and
// S_DONE to the output register, and so does a fault while free frames remain.
// A fault once all FRAMES frames are in use scans the stamp memory one frame
// per cycle and then passes S_OWN and S_EVICT; that scan over the stamp memory
// read port sets the worst case. One address is in work at a time; in_tready is
// high when the sequencer is idle.
// The result sits in an output register, so a new address is taken while a
// finished result waits; if out_tready stays low the next result waits in
// the sequencer and no further address is accepted.
// Reset clears the tlb, the page table valid bits, the frame count and the
// stamp clock; no clearing pass is needed, the block is ready the cycle
// after reset is released.
module tlb_lru_address_translator
  import tlat_pkg::*;
#(
  parameter int PAGE_BYTES  = 256,
  parameter int FRAMES      = 128,
  parameter int TLB_ENTRIES = 16,
  parameter int PAGES       = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // logical_address[15:0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_BITS-1:0] out_tdata   // physical_address[14:0], frame_number[21:15],
                                          // tlb_hit[22], page_fault[23],
                                          // evict_valid[24], evicted_page[32:25], zero
);

  localparam int PAGE_W  = $clog2(PAGES);
  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int CNT_W   = $clog2(FRAMES + 1);

  state_t              state_r, state_nxt;
  logic [PAGE_W-1:0]   page_r;
  logic [7:0]          off_r;
  logic [FRAME_W-1:0]  frame_r;
  logic                hit_r, fault_r, evict_r;
  logic [PAGE_W-1:0]   vpage_r;
  logic [CNT_W-1:0]    free_cnt_r;
  logic [31:0]         clock_r;
  logic [PAGES-1:0]    pm_valid_r;
  logic [FRAME_W-1:0]  pm_mem [PAGES];
  logic [FRAME_W-1:0]  pm_q_r;
  logic                out_valid_r;
  logic [OUT_BITS-1:0] out_data_r;

  logic                in_beat;
  logic [15:0]         pg_ext;
  logic [PAGE_W-1:0]   in_page;
  logic                tlb_hit;
  logic [FRAME_W-1:0]  tlb_frame;
  tlb_ctl_t            tlb_ctl;
  logic [FRAME_W-1:0]  fill_frame;
  logic [PAGE_W-1:0]   owner_q;
  logic [PAGE_W-1:0]   victim;
  logic                scan_start, scan_done;
  logic [FRAME_W-1:0]  best_idx;
  logic                stamp_we;
  logic [FRAME_W-1:0]  stamp_waddr;
  logic                commit;
  logic [FRAME_W-1:0]  commit_frame;
  logic                free_left;
  logic                out_load;
  logic [31:0]         phys_w;
  logic [31:0]         frame_w;
  logic [15:0]         vpage_w;

  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign pg_ext     = {8'h00, in_tdata[15:8]};
  assign in_page    = pg_ext[PAGE_W-1:0];
  assign free_left  = free_cnt_r < CNT_W'(FRAMES);
  assign victim     = owner_q;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // page table frame memory, read at the input beat
  always_ff @(posedge clk) begin
    if (commit) begin
      pm_mem[page_r] <= commit_frame;
    end
    if (in_beat) begin
      pm_q_r <= pm_mem[in_page];
    end
  end

  // lookup decisions per state
  always_comb begin
    state_nxt    = state_r;
    tlb_ctl      = '0;
    fill_frame   = pm_q_r;
    scan_start   = 1'b0;
    stamp_we     = 1'b0;
    stamp_waddr  = tlb_frame;
    commit       = 1'b0;
    commit_frame = free_cnt_r[FRAME_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_beat) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        if (tlb_hit) begin
          stamp_we  = 1'b1;
          state_nxt = S_DONE;
        end else if (pm_valid_r[page_r]) begin
          tlb_ctl.fill_en = 1'b1;
          state_nxt       = S_DONE;
        end else if (free_left) begin
          commit          = 1'b1;
          stamp_we        = 1'b1;
          stamp_waddr     = commit_frame;
          tlb_ctl.fill_en = 1'b1;
          fill_frame      = commit_frame;
          state_nxt       = S_DONE;
        end else begin
          scan_start = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_OWN;
      end
      S_OWN: begin
        state_nxt = S_EVICT;
      end
      S_EVICT: begin
        commit          = 1'b1;
        commit_frame    = frame_r;
        stamp_we        = 1'b1;
        stamp_waddr     = frame_r;
        tlb_ctl.fill_en = 1'b1;
        tlb_ctl.inv_en  = 1'b1;
        fill_frame      = frame_r;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_cnt_r  <= '0;
      clock_r     <= '0;
      pm_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (stamp_we && clock_r != STAMP_MAX) begin
        clock_r <= clock_r + 32'd1;
      end
      if (commit && state_r == S_LOOK) begin
        free_cnt_r <= free_cnt_r + 1'b1;
      end
      if (state_r == S_EVICT) begin
        pm_valid_r[victim] <= 1'b0;
      end
      if (commit) begin
        pm_valid_r[page_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      page_r  <= in_page;
      off_r   <= in_tdata[7:0];
      hit_r   <= 1'b0;
      fault_r <= 1'b0;
      evict_r <= 1'b0;
      vpage_r <= '0;
    end
    if (state_r == S_LOOK) begin
      if (tlb_hit) begin
        frame_r <= tlb_frame;
        hit_r   <= 1'b1;
      end else if (pm_valid_r[page_r]) begin
        frame_r <= pm_q_r;
      end else begin
        frame_r <= commit_frame;
        fault_r <= 1'b1;
      end
    end
    if (state_r == S_SCAN && scan_done) begin
      frame_r <= best_idx;
    end
    if (state_r == S_EVICT) begin
      evict_r <= 1'b1;
      vpage_r <= victim;
    end
  end

  // result packing
  assign frame_w = 32'(frame_r);
  assign phys_w  = (frame_w << OFF_W) + 32'(off_r);
  assign vpage_w = 16'(vpage_r);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {7'd0, vpage_w[EPAGE_W-1:0], evict_r, fault_r, hit_r,
                     frame_w[FNUM_W-1:0], phys_w[PHYS_W-1:0]};
    end
  end

  tlat_tlb #(
    .ENTRIES (TLB_ENTRIES),
    .PAGE_W  (PAGE_W),
    .FRAME_W (FRAME_W)
  ) u_tlb (
    .clk        (clk),
    .rst_n      (rst_n),
    .look_page  (page_r),
    .look_hit   (tlb_hit),
    .look_frame (tlb_frame),
    .ctl        (tlb_ctl),
    .fill_page  (page_r),
    .fill_frame (fill_frame),
    .inv_page   (victim)
  );

  tlat_frames #(
    .FRAMES  (FRAMES),
    .PAGE_W  (PAGE_W),
    .FRAME_W (FRAME_W)
  ) u_frames (
    .clk         (clk),
    .rst_n       (rst_n),
    .scan_start  (scan_start),
    .scan_done   (scan_done),
    .best_idx    (best_idx),
    .stamp_we    (stamp_we),
    .stamp_waddr (stamp_waddr),
    .stamp_wdata (clock_r),
    .owner_we    (commit),
    .owner_waddr (commit_frame),
    .owner_wdata (page_r),
    .owner_re    (state_r == S_SCAN && scan_done),
    .owner_raddr (best_idx),
    .owner_rdata (owner_q)
  );

`ifndef SYNTH
  // a tlb hit is never a fault
  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[22] && out_tdata[23]))
    else $error("tlb hit reported with page fault");

  // eviction only on a fault
  a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |-> out_tdata[23])
    else $error("eviction without page fault");

  // frame count never passes the frame total
  a_free_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CNT_W'(FRAMES))
    else $error("frame count overflow");

  // an eviction is reached only with all frames handed out
  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    scan_start |-> !free_left)
    else $error("lru scan with free frames left");
`endif

endmodule
